// File: design/mmhq_pkg.sv
// ----------------------------------------------------------------------------
// Min-max heap queue package
// Shared types, codes and defaults of the min-max heap queue unit.
// ----------------------------------------------------------------------------
package mmhq_pkg;

   localparam int CAPACITY_DEF  = 1024;
   localparam int KEY_WIDTH_DEF = 32;

   // Fixed field widths of the stream words.
   localparam int KIND_W   = 3;
   localparam int NKEY_W   = 32;
   localparam int POS_W    = 11;
   localparam int DELTA_W  = 31;
   localparam int KOUT_W   = 32;
   localparam int CODE_W   = 2;
   localparam int COUNT_W  = 11;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;

   // Candidate counts of the two scans: the top three slots, or the two
   // children and four grandchildren of a node.
   localparam int ROOT_SCAN = 3;
   localparam int DESC_SCAN = 6;

   typedef enum logic [2:0] {
      REQ_INSERT     = 3'd0,
      REQ_DELETE_MIN = 3'd1,
      REQ_DELETE_MAX = 3'd2,
      REQ_FIND_MIN   = 3'd3,
      REQ_FIND_MAX   = 3'd4,
      REQ_INC_KEY    = 3'd5,
      REQ_DEC_KEY    = 3'd6
   } req_kind_type;

   typedef enum logic [1:0] {
      RC_OK      = 2'd0,
      RC_EMPTY   = 2'd1,
      RC_FULL    = 2'd2,
      RC_BAD_POS = 2'd3
   } rsp_code_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_INS_INIT,
      CMD_RD_ROOT,
      CMD_TAKE_ROOT,
      CMD_RD_LAST,
      CMD_DEL_LOAD,
      CMD_ROOT_INIT,
      CMD_DESC_INIT,
      CMD_SCAN_RD,
      CMD_SCAN_CMP,
      CMD_MAX_TAKE,
      CMD_RD_POS,
      CMD_KC_LOAD,
      CMD_TD_MOVE,
      CMD_RD_PARENT,
      CMD_TD_FIX,
      CMD_WRITE_K,
      CMD_BU_INIT,
      CMD_LOAD_K,
      CMD_BU_FIRST,
      CMD_RD_GRAND,
      CMD_BS_STEP,
      CMD_FINISH
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_INS,
      S_RD_ROOT,
      S_TAKE_ROOT,
      S_RD_LAST,
      S_DEL_LOAD,
      S_MAX_INIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_MAX_TAKE,
      S_RD_POS,
      S_KC_LOAD,
      S_TD_TEST,
      S_TD_MOVE,
      S_TD_RDP,
      S_TD_FIX,
      S_TD_END,
      S_BU_SELF,
      S_BU_LOADK,
      S_BU_RDP,
      S_BU_FIRST,
      S_BS_RD,
      S_BS_CHK,
      S_BU_END,
      S_FINISH
   } state_type;

   typedef struct packed {
      req_kind_type op;
      logic         run;
      logic         has_child;
      logic         scan_end;
      logic         scan_root;
      logic         td_moves;
      logic         best_grand;
      logic         idx_gt1;
      logic         idx_gt3;
      logic         bs_moves;
   } dp_status_type;

endpackage

// File: design/mmhq_ram.sv
// ----------------------------------------------------------------------------
// Min-max heap queue RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/mmhq_dp.sv
// ----------------------------------------------------------------------------
// Min-max heap queue datapath
// Heap memory, entry count, walk registers and result registers.
// ----------------------------------------------------------------------------
module mmhq_dp
   import mmhq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [NKEY_W-1:0]     req_new_key,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DELTA_W-1:0]    req_delta,
   output dp_status_type         status,
   output logic [KOUT_W-1:0]     rsp_key,
   output logic [CODE_W-1:0]     rsp_code,
   output logic [COUNT_W-1:0]    rsp_count
);

   localparam int AW = $clog2(CAPACITY + 1);
   localparam int CW = AW + 2;
   localparam int RW = $clog2(CAPACITY);
   localparam int PW = (AW > POS_W) ? AW : POS_W;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   logic [KIND_W-1:0]  op_ff, op_in;
   logic [NKEY_W-1:0]  nkey_ff, nkey_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      best_ff, best_in;
   logic [2:0]         kidx_ff, kidx_in;
   logic               root_ff, root_in;
   logic               side_ff, side_in;
   key_type            k_ff, k_in;
   key_type            bk_ff, bk_in;
   key_type            res_ff, res_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [KOUT_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          wr_en;
   logic [AW-1:0] wr_pos;
   key_type       wr_data;
   logic [AW-1:0] rd_pos;
   key_type       rd_data;
   logic [KEY_WIDTH-1:0] rd_raw;

   rsp_code_type  code_c;
   logic [CW-1:0] cand;
   logic [AW-1:0] pos_w;
   key_type       dext;
   key_type       kv;
   logic          lvl_c;

   // Level parity of a position: true on a min level.
   function automatic logic min_level(input logic [AW-1:0] v);
      logic par;
      par = 1'b0;
      for (int b = 1; b < AW; b++) begin
         if (v[b]) begin
            par = b[0];
         end
      end
      return ~par;
   endfunction

   mmhq_ram #(
      .WIDTH(KEY_WIDTH),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(RW'(wr_pos - AW'(1))),
      .wr_data(wr_data),
      .rd_addr(RW'(rd_pos - AW'(1))),
      .rd_data(rd_raw)
   );

   assign rd_data = key_type'(rd_raw);
   assign pos_w   = AW'(pos_ff);
   assign dext    = key_type'(delta_ff);
   assign kv      = (op_ff == REQ_INC_KEY) ? key_type'(rd_data + dext)
                                           : key_type'(rd_data - dext);

   // Candidate of the current scan step.
   always_comb begin
      if (root_ff) begin
         cand = CW'(kidx_ff) + CW'(1);
      end else if (kidx_ff == 3'd0) begin
         cand = CW'(idx_ff) << 1;
      end else if (kidx_ff == 3'd1) begin
         cand = (CW'(idx_ff) << 1) + CW'(1);
      end else begin
         cand = (CW'(idx_ff) << 2) + CW'(kidx_ff - 3'd2);
      end
   end

   // Result code of the request just taken.
   always_comb begin
      case (op_ff)
         REQ_INSERT: begin
            code_c = (cnt_ff >= AW'(CAPACITY)) ? RC_FULL : RC_OK;
         end
         REQ_DELETE_MIN, REQ_DELETE_MAX, REQ_FIND_MIN, REQ_FIND_MAX: begin
            code_c = (cnt_ff == '0) ? RC_EMPTY : RC_OK;
         end
         REQ_INC_KEY, REQ_DEC_KEY: begin
            if (cnt_ff == '0) begin
               code_c = RC_EMPTY;
            end else if (pos_ff == '0 || PW'(pos_ff) > PW'(cnt_ff)) begin
               code_c = RC_BAD_POS;
            end else begin
               code_c = RC_OK;
            end
         end
         default: begin
            code_c = RC_OK;
         end
      endcase
   end

   always_comb begin
      status.op         = req_kind_type'(op_ff);
      status.run        = (code_c == RC_OK) && (op_ff <= KIND_W'(REQ_DEC_KEY));
      status.has_child  = (CW'(idx_ff) << 1) <= CW'(cnt_ff);
      status.scan_end   = (root_ff ? (kidx_ff == 3'(ROOT_SCAN))
                                   : (kidx_ff == 3'(DESC_SCAN)))
                          || (cand > CW'(cnt_ff));
      status.scan_root  = root_ff;
      status.td_moves   = side_ff ? (bk_ff < k_ff) : (k_ff < bk_ff);
      status.best_grand = CW'(best_ff) >= (CW'(idx_ff) << 2);
      status.idx_gt1    = idx_ff > AW'(1);
      status.idx_gt3    = idx_ff > AW'(3);
      status.bs_moves   = side_ff ? (k_ff < rd_data) : (rd_data < k_ff);
   end

   always_comb begin
      op_in        = op_ff;
      nkey_in      = nkey_ff;
      pos_in       = pos_ff;
      delta_in     = delta_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      kidx_in      = kidx_ff;
      root_in      = root_ff;
      side_in      = side_ff;
      k_in         = k_ff;
      bk_in        = bk_ff;
      res_in       = res_ff;
      code_in      = code_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_pos       = idx_ff;
      wr_data      = k_ff;
      rd_pos       = AW'(1);
      lvl_c        = min_level(idx_ff);
      case (cmd)
         CMD_LOAD: begin
            op_in    = req_kind;
            nkey_in  = req_new_key;
            pos_in   = req_position;
            delta_in = req_delta;
         end
         CMD_START: begin
            code_in = code_c;
            res_in  = '0;
         end
         CMD_INS_INIT: begin
            cnt_in = cnt_ff + AW'(1);
            idx_in = cnt_ff + AW'(1);
            k_in   = key_type'($signed(nkey_ff));
            res_in = key_type'($signed(nkey_ff));
         end
         CMD_RD_ROOT: begin
            rd_pos = AW'(1);
         end
         CMD_TAKE_ROOT: begin
            res_in  = rd_data;
            best_in = AW'(1);
         end
         CMD_RD_LAST: begin
            rd_pos = cnt_ff;
         end
         CMD_DEL_LOAD: begin
            k_in    = rd_data;
            cnt_in  = cnt_ff - AW'(1);
            idx_in  = best_ff;
            side_in = min_level(best_ff);
         end
         CMD_ROOT_INIT: begin
            kidx_in = '0;
            root_in = 1'b1;
            side_in = 1'b0;
         end
         CMD_DESC_INIT: begin
            kidx_in = '0;
            root_in = 1'b0;
         end
         CMD_SCAN_RD: begin
            rd_pos = AW'(cand);
         end
         CMD_SCAN_CMP: begin
            if (kidx_ff == '0 || (side_ff ? (rd_data < bk_ff) : (bk_ff < rd_data))) begin
               best_in = AW'(cand);
               bk_in   = rd_data;
            end
            kidx_in = kidx_ff + 3'd1;
         end
         CMD_MAX_TAKE: begin
            res_in = bk_ff;
         end
         CMD_RD_POS: begin
            rd_pos = pos_w;
         end
         CMD_KC_LOAD: begin
            k_in    = kv;
            res_in  = kv;
            idx_in  = pos_w;
            side_in = min_level(pos_w);
         end
         CMD_TD_MOVE: begin
            wr_en   = 1'b1;
            wr_data = bk_ff;
            idx_in  = best_ff;
         end
         CMD_RD_PARENT: begin
            rd_pos = idx_ff >> 1;
         end
         CMD_TD_FIX: begin
            if (side_ff ? (rd_data < k_ff) : (k_ff < rd_data)) begin
               wr_en  = 1'b1;
               wr_pos = idx_ff >> 1;
               k_in   = rd_data;
            end
         end
         CMD_WRITE_K: begin
            wr_en = 1'b1;
         end
         CMD_BU_INIT: begin
            idx_in = pos_w;
            rd_pos = pos_w;
         end
         CMD_LOAD_K: begin
            k_in = rd_data;
         end
         CMD_BU_FIRST: begin
            // A key on a min level above its max-level parent swaps with it
            // and climbs the max levels; the mirror case climbs the min levels.
            if (lvl_c ? (rd_data < k_ff) : (k_ff < rd_data)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff >> 1;
               side_in = ~lvl_c;
            end else begin
               side_in = lvl_c;
            end
         end
         CMD_RD_GRAND: begin
            rd_pos = idx_ff >> 2;
         end
         CMD_BS_STEP: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_ff >> 2;
         end
         CMD_FINISH: begin
            rsp_key_in   = KOUT_W'(res_ff);
            rsp_code_in  = code_ff;
            rsp_count_in = COUNT_W'(cnt_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      nkey_ff      <= nkey_in;
      pos_ff       <= pos_in;
      delta_ff     <= delta_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      kidx_ff      <= kidx_in;
      root_ff      <= root_in;
      side_ff      <= side_in;
      k_ff         <= k_in;
      bk_ff        <= bk_in;
      res_ff       <= res_in;
      code_ff      <= code_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_key   = rsp_key_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_count = rsp_count_ff;

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= AW'(CAPACITY))
      else $error("entry count above capacity");

   a_cnt_step : assert property (@(posedge clock) disable iff (reset)
      ##1 (cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + AW'(1)
           || cnt_ff == $past(cnt_ff) - AW'(1)))
      else $error("entry count moved by more than one");

   a_wr_range : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_pos != '0 && wr_pos <= AW'(CAPACITY)))
      else $error("heap write outside positions 1 to capacity");

endmodule

// File: design/mmhq_ctrl.sv
// ----------------------------------------------------------------------------
// Min-max heap queue controller
// Sequences each request through the datapath one micro-step a cycle; a stalled output holds finish.
// ----------------------------------------------------------------------------
module mmhq_ctrl
   import mmhq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fin;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      fin      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd      = CMD_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd = CMD_START;
            if (!status.run) begin
               state_in = S_FINISH;
            end else begin
               case (status.op)
                  REQ_INSERT:                   state_in = S_INS;
                  REQ_DELETE_MIN, REQ_FIND_MIN: state_in = S_RD_ROOT;
                  REQ_DELETE_MAX, REQ_FIND_MAX: state_in = S_MAX_INIT;
                  REQ_INC_KEY, REQ_DEC_KEY:     state_in = S_RD_POS;
                  default:                      state_in = S_FINISH;
               endcase
            end
         end
         S_INS: begin
            cmd      = CMD_INS_INIT;
            state_in = S_BU_RDP;
         end
         S_RD_ROOT: begin
            cmd      = CMD_RD_ROOT;
            state_in = S_TAKE_ROOT;
         end
         S_TAKE_ROOT: begin
            cmd      = CMD_TAKE_ROOT;
            state_in = (status.op == REQ_FIND_MIN) ? S_FINISH : S_RD_LAST;
         end
         S_RD_LAST: begin
            cmd      = CMD_RD_LAST;
            state_in = S_DEL_LOAD;
         end
         S_DEL_LOAD: begin
            cmd      = CMD_DEL_LOAD;
            state_in = S_TD_TEST;
         end
         S_MAX_INIT: begin
            cmd      = CMD_ROOT_INIT;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = status.scan_root ? S_MAX_TAKE : S_TD_MOVE;
            end else begin
               cmd      = CMD_SCAN_RD;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd      = CMD_SCAN_CMP;
            state_in = S_SCAN_RD;
         end
         S_MAX_TAKE: begin
            cmd      = CMD_MAX_TAKE;
            state_in = (status.op == REQ_FIND_MAX) ? S_FINISH : S_RD_LAST;
         end
         S_RD_POS: begin
            cmd      = CMD_RD_POS;
            state_in = S_KC_LOAD;
         end
         S_KC_LOAD: begin
            cmd      = CMD_KC_LOAD;
            state_in = S_TD_TEST;
         end
         S_TD_TEST: begin
            if (status.has_child) begin
               cmd      = CMD_DESC_INIT;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_TD_END;
            end
         end
         S_TD_MOVE: begin
            if (!status.td_moves) begin
               state_in = S_TD_END;
            end else begin
               cmd      = CMD_TD_MOVE;
               state_in = status.best_grand ? S_TD_RDP : S_TD_END;
            end
         end
         S_TD_RDP: begin
            cmd      = CMD_RD_PARENT;
            state_in = S_TD_FIX;
         end
         S_TD_FIX: begin
            cmd      = CMD_TD_FIX;
            state_in = S_TD_TEST;
         end
         S_TD_END: begin
            cmd = CMD_WRITE_K;
            if (status.op == REQ_INC_KEY || status.op == REQ_DEC_KEY) begin
               state_in = S_BU_SELF;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BU_SELF: begin
            cmd      = CMD_BU_INIT;
            state_in = S_BU_LOADK;
         end
         S_BU_LOADK: begin
            cmd      = CMD_LOAD_K;
            state_in = S_BU_RDP;
         end
         S_BU_RDP: begin
            if (status.idx_gt1) begin
               cmd      = CMD_RD_PARENT;
               state_in = S_BU_FIRST;
            end else begin
               state_in = S_BU_END;
            end
         end
         S_BU_FIRST: begin
            cmd      = CMD_BU_FIRST;
            state_in = S_BS_RD;
         end
         S_BS_RD: begin
            if (status.idx_gt3) begin
               cmd      = CMD_RD_GRAND;
               state_in = S_BS_CHK;
            end else begin
               state_in = S_BU_END;
            end
         end
         S_BS_CHK: begin
            if (status.bs_moves) begin
               cmd      = CMD_BS_STEP;
               state_in = S_BS_RD;
            end else begin
               state_in = S_BU_END;
            end
         end
         S_BU_END: begin
            cmd      = CMD_WRITE_K;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd      = CMD_FINISH;
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_START))
      else $error("accepted word did not start a request");

   a_finish_slot : assert property (@(posedge clock) disable iff (reset)
      fin |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken word");

   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_LOAD) |-> (state_ff == S_IDLE))
      else $error("request fields loaded outside idle");

endmodule

// File: design/min_max_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// Min-max heap queue unit
// Double-ended priority queue held as a min-max heap in a RAM with one read
// port and one write port.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Word contents (lowest bit first)
//   req_*     in          tuser: req_type; tdata: new_key, position, delta
//   rsp_*     out         tuser: status;   tdata: key_out, entry_count
//
// Each request takes one word in and gives one word out, one request at a
// time, and the unit returns to idle before the next word is taken. Find
// min reads the root, and find max scans the top three slots with one read
// and one compare per slot. A trickle-down step scans up to six candidates
// the same way, then makes the move and, after a grandchild move, checks
// the parent; a bubble-up step reads and checks one grandparent. The scans
// read one slot at a time, set by the one read port of the heap RAM.
// Reset is synchronous and active high; it empties the queue but does not
// clear the RAM. A new word is taken while a result waits on the output;
// a stalled output holds the next finished request until the waiting word is taken.
//
module min_max_heap_queue_unit
   import mmhq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request words.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // new_key[31:0], position[42:32],
                                             // delta[73:43], zero fill
   input  logic [KIND_W-1:0]     req_tuser,  // req_type[2:0]
   // Result words.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // key_out[31:0], entry_count[42:32],
                                             // zero fill
   output logic [CODE_W-1:0]     rsp_tuser   // status[1:0]
);

   dp_status_type          status;
   cmd_type                cmd;
   logic [KOUT_W-1:0]      rsp_key;
   logic [CODE_W-1:0]      rsp_code;
   logic [COUNT_W-1:0]     rsp_count;

   // The controller walks the heap; the datapath owns the RAM and registers.
   mmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mmhq_dp #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_kind    (req_tuser),
      .req_new_key (req_tdata[NKEY_W-1:0]),
      .req_position(req_tdata[NKEY_W+POS_W-1:NKEY_W]),
      .req_delta   (req_tdata[NKEY_W+POS_W+DELTA_W-1:NKEY_W+POS_W]),
      .status      (status),
      .rsp_key     (rsp_key),
      .rsp_code    (rsp_code),
      .rsp_count   (rsp_count)
   );

   // The result word is packed from the datapath's output registers.
   assign rsp_tdata = {{(RSP_DATA_W - KOUT_W - COUNT_W){1'b0}}, rsp_count, rsp_key};
   assign rsp_tuser = rsp_code;

endmodule

// File: tb/min_max_heap_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// Min-max heap queue unit testbench
// Drives request words into the heap queue, keeps its own min-max heap
// model, and checks every result word against the predicted key, status
// and entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module min_max_heap_queue_unit_tb;
   import mmhq_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] key;
      logic [1:0]  code;
      logic [10:0] count;
   } heap_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [CODE_W-1:0]     rsp_tuser;

   // Model of the heap: keys at positions 1..CAP and the number held.
   logic signed [31:0] model_keys [1:CAP];
   int                 model_count;

   heap_result_type pending_results [$];
   int  mismatch_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  idle_cycles = 0;
   int  rsp_hold = 0;
   bit  rsp_idling_on = 1'b1;
   bit  req_idling_on = 1'b1;

   min_max_heap_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Heap model helpers.
   // ---------------------------------------------------------------------
   function automatic bit min_level(int i);
      int lvl;
      lvl = 0;
      while (i > 1) begin
         i = i >> 1;
         lvl++;
      end
      return (lvl % 2) == 0;
   endfunction

   function automatic void swap_slots(int a, int b);
      logic signed [31:0] t;
      t = model_keys[a];
      model_keys[a] = model_keys[b];
      model_keys[b] = t;
   endfunction

   // True when slot c beats slot ref_slot in the wanted direction.
   function automatic bit beats(int c, int ref_slot, bit want_min);
      return want_min ? (model_keys[c] < model_keys[ref_slot])
                      : (model_keys[ref_slot] < model_keys[c]);
   endfunction

   function automatic int best_descendant(int i, bit want_min);
      int best;
      best = 2 * i;
      for (int c = 2 * i; c <= 2 * i + 1 && c <= model_count; c++)
         if (beats(c, best, want_min)) best = c;
      for (int c = 4 * i; c <= 4 * i + 3 && c <= model_count; c++)
         if (beats(c, best, want_min)) best = c;
      return best;
   endfunction

   function automatic void sift_down(int i);
      int m;
      int p;
      bit is_min;
      is_min = min_level(i);
      while (2 * i <= model_count) begin
         m = best_descendant(i, is_min);
         if (!beats(m, i, is_min)) return;
         swap_slots(m, i);
         if (m < 4 * i) return;
         p = m / 2;
         // A grandchild move may leave the new key out of order with its parent.
         if (is_min ? (model_keys[p] < model_keys[m]) : (model_keys[m] < model_keys[p]))
            swap_slots(m, p);
         i = m;
      end
   endfunction

   function automatic void sift_up_side(int i, bit is_min);
      int g;
      while (i > 3) begin
         g = i / 4;
         if (!beats(i, g, is_min)) return;
         swap_slots(i, g);
         i = g;
      end
   endfunction

   function automatic void sift_up(int i);
      if (min_level(i)) begin
         if (i > 1 && model_keys[i / 2] < model_keys[i]) begin
            swap_slots(i, i / 2);
            sift_up_side(i / 2, 1'b0);
         end else begin
            sift_up_side(i, 1'b1);
         end
      end else begin
         if (i > 1 && model_keys[i] < model_keys[i / 2]) begin
            swap_slots(i, i / 2);
            sift_up_side(i / 2, 1'b1);
         end else begin
            sift_up_side(i, 1'b0);
         end
      end
   endfunction

   function automatic int max_slot();
      int best;
      best = 1;
      for (int i = 1; i <= model_count && i <= 3; i++)
         if (model_keys[best] < model_keys[i]) best = i;
      return best;
   endfunction

   // Applies one request to the model and returns the expected result.
   function automatic heap_result_type apply_request(logic [2:0] kind,
                                                     logic signed [31:0] nkey,
                                                     int pos, logic [30:0] delta);
      heap_result_type r;
      int m;
      r.key  = '0;
      r.code = RC_OK;
      case (kind)
         REQ_INSERT: begin
            if (model_count >= CAP) begin
               r.code = RC_FULL;
            end else begin
               model_count++;
               model_keys[model_count] = nkey;
               r.key = nkey;
               sift_up(model_count);
            end
         end
         REQ_DELETE_MIN: begin
            if (model_count == 0) begin
               r.code = RC_EMPTY;
            end else begin
               r.key = model_keys[1];
               model_keys[1] = model_keys[model_count];
               model_count--;
               if (model_count >= 2) sift_down(1);
            end
         end
         REQ_DELETE_MAX: begin
            if (model_count == 0) begin
               r.code = RC_EMPTY;
            end else begin
               m = max_slot();
               r.key = model_keys[m];
               model_keys[m] = model_keys[model_count];
               model_count--;
               if (m <= model_count) sift_down(m);
            end
         end
         REQ_FIND_MIN: begin
            if (model_count == 0) r.code = RC_EMPTY;
            else r.key = model_keys[1];
         end
         REQ_FIND_MAX: begin
            if (model_count == 0) r.code = RC_EMPTY;
            else r.key = model_keys[max_slot()];
         end
         REQ_INC_KEY, REQ_DEC_KEY: begin
            if (model_count == 0) begin
               r.code = RC_EMPTY;
            end else if (pos == 0 || pos > model_count) begin
               r.code = RC_BAD_POS;
            end else begin
               // Key arithmetic wraps at 32 bits.
               if (kind == REQ_INC_KEY)
                  model_keys[pos] = model_keys[pos] + $signed({1'b0, delta});
               else
                  model_keys[pos] = model_keys[pos] - $signed({1'b0, delta});
               r.key = model_keys[pos];
               sift_down(pos);
               sift_up(pos);
            end
         end
         default: ;
      endcase
      r.count = model_count[10:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one word per call, with optional random idling first.
   // Valid stays high from one word to the next unless the sender idles.
   // ---------------------------------------------------------------------
   task automatic send_request(logic [2:0] kind, logic [31:0] nkey,
                               logic [10:0] pos, logic [30:0] delta);
      int gap;
      if (req_idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, delta, pos, nkey};
      pending_results.push_back(apply_request(kind, nkey, pos, delta));
      words_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic random_request(int insert_weight);
      logic [2:0]  kind;
      logic [10:0] pos;
      logic [30:0] delta;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) kind = REQ_INSERT;
      else kind = 3'($urandom_range(REQ_DELETE_MIN, REQ_DEC_KEY));
      // Mostly valid positions, sometimes anything the field allows.
      if (model_count > 0 && $urandom_range(0, 9) != 0)
         pos = 11'($urandom_range(1, model_count));
      else
         pos = 11'($urandom);
      case ($urandom_range(0, 3))
         0: delta = 31'($urandom_range(0, 15));
         1: delta = 31'h7fff_ffff;
         default: delta = 31'($urandom);
      endcase
      send_request(kind, $urandom, pos, delta);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall bursts and the field-by-field comparison.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1) rsp_tready <= 1'b1;
      end else if (rsp_tready && rsp_tvalid && rsp_idling_on &&
                   $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(1, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      heap_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: result word with nothing expected: key %0d code %0d",
                        $signed(rsp_tdata[31:0]), rsp_tuser);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[31:0] !== exp_r.key || rsp_tuser !== exp_r.code ||
                rsp_tdata[42:32] !== exp_r.count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: word %0d expected key %0d code %0d count %0d,",
                            " got key %0d code %0d count %0d"},
                           words_checked, $signed(exp_r.key), exp_r.code, exp_r.count,
                           $signed(rsp_tdata[31:0]), rsp_tuser, rsp_tdata[42:32]);
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------
   // Empty-queue cases, the unused code, and the extreme keys.
   task automatic test_directed();
      send_request(REQ_DELETE_MIN, 0, 0, 0);
      send_request(REQ_DELETE_MAX, 0, 0, 0);
      send_request(REQ_FIND_MIN, 0, 0, 0);
      send_request(REQ_FIND_MAX, 0, 0, 0);
      send_request(REQ_INC_KEY, 0, 1, 5);
      send_request(REQ_DEC_KEY, 0, 1, 5);
      send_request(3'd7, 32'hffff_ffff, 11'h7ff, 31'h7fff_ffff);
      send_request(REQ_INSERT, 32'h8000_0000, 0, 0);
      send_request(REQ_INSERT, 32'h7fff_ffff, 0, 0);
      send_request(REQ_INSERT, 32'd5, 0, 0);
      send_request(REQ_INSERT, 32'd5, 0, 0);
      send_request(REQ_FIND_MIN, 0, 0, 0);
      send_request(REQ_FIND_MAX, 0, 0, 0);
      send_request(REQ_INC_KEY, 0, 0, 1);
      send_request(REQ_DEC_KEY, 0, 11'd5, 1);
      send_request(REQ_INC_KEY, 0, 11'h7ff, 1);
      // Wrap past the top and bottom of the key range.
      send_request(REQ_INC_KEY, 0, 11'd2, 31'h7fff_ffff);
      send_request(REQ_DEC_KEY, 0, 11'd1, 31'h7fff_ffff);
      send_request(REQ_DELETE_MAX, 0, 0, 0);
      send_request(REQ_DELETE_MIN, 0, 0, 0);
      send_request(REQ_DELETE_MIN, 0, 0, 0);
      send_request(REQ_DELETE_MIN, 0, 0, 0);
      send_request(REQ_DELETE_MIN, 0, 0, 0);
   endtask

   // Mixed traffic that grows and shrinks the heap.
   task automatic test_random_mix(int n, int insert_weight);
      repeat (n) random_request(insert_weight);
   endtask

   // Fills the heap to capacity, pushes against full, then takes some out.
   task automatic test_full_heap();
      while (model_count < CAP) send_request(REQ_INSERT, $urandom, 0, 0);
      send_request(REQ_INSERT, 32'h1234_5678, 0, 0);
      test_random_mix(16, 50);
      repeat (20)
         send_request($urandom_range(0, 1) ? REQ_DELETE_MIN : REQ_DELETE_MAX, 0, 0, 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(40, 45);
      // Hold the sender until the heap has answered everything.
      wait_drained();
      test_random_mix(30, 65);
      test_full_heap();
      // Last stretch with both sides always ready.
      req_idling_on = 1'b0;
      rsp_idling_on = 1'b0;
      test_random_mix(20, 40);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Sent %0d request words and checked %0d result words, including",
               words_sent, words_checked);
      $display("empty, full, bad-position and wrapping key changes.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: min_max_heap_queue_unit.f
design/mmhq_pkg.sv
design/mmhq_ram.sv
design/mmhq_dp.sv
design/mmhq_ctrl.sv
design/min_max_heap_queue_unit.sv
tb/min_max_heap_queue_unit_tb.sv
